/* src/mlpr_pkg.sv */
package mlpr_pkg;

    localparam int BUF_BYTES = 1024;
    localparam int AW = $clog2(BUF_BYTES);
    localparam int FW = $clog2(BUF_BYTES + 1);

    localparam logic [7:0]  END_BYTE       = 8'h03;
    localparam logic [7:0]  START_MIN      = 8'h02;
    localparam logic [7:0]  START_MAX      = 8'h04;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [7:0]  CMD_GET_VALUES = 8'd4;
    localparam logic [15:0] MIN_VALUES_LEN = 16'd60;
    localparam logic [15:0] OFF_TEMP       = 16'd1;
    localparam logic [15:0] OFF_CURRENT    = 16'd9;
    localparam logic [15:0] OFF_RPM        = 16'd23;
    localparam logic [15:0] OFF_FAULT      = 16'd59;

    typedef struct packed {
        logic          start;
        logic          is_end;
        logic [AW-1:0] end_idx;
        logic [AW-1:0] head;
    } t_scan_req;

    typedef struct packed {
        logic          done;
        logic          accepted;
        logic          updated;
        logic [AW-1:0] start_idx;
        logic [9:0]    payload_len;
        logic [7:0]    command;
        logic [15:0]   temperature;
        logic [31:0]   current;
        logic [31:0]   rpm;
        logic [7:0]    fault;
    } t_scan_res;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // logical buffer index to ram address, oldest byte sits at head
    function automatic logic [AW-1:0] buf_addr(input logic [AW-1:0] head,
                                              input logic [AW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, idx};
        if (sum >= (AW+1)'(BUF_BYTES)) begin
            sum = sum - (AW+1)'(BUF_BYTES);
        end
        return sum[AW-1:0];
    endfunction

endpackage

/* src/mlpr_ram.sv */
module mlpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/mlpr_scan.sv */
module mlpr_scan import mlpr_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_scan_req     i_req,
    input  logic          i_ack,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr,
    input  logic [7:0]    i_rd_data,
    output t_scan_res     o_res
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CRCH = 4'd1;
    localparam logic [3:0] S_CRCL = 4'd2;
    localparam logic [3:0] S_TAG  = 4'd3;
    localparam logic [3:0] S_LEN  = 4'd4;
    localparam logic [3:0] S_CRC  = 4'd5;
    localparam logic [3:0] S_CHK  = 4'd6;
    localparam logic [3:0] S_DONE = 4'd7;

    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_end, n_end;
    logic [AW-1:0] r_s, n_s;
    logic [AW-1:0] r_ds, n_ds;
    logic [AW-1:0] r_dl, n_dl;
    logic [AW-1:0] r_off, n_off;
    logic [1:0]    r_nlen, n_nlen;
    logic [1:0]    r_j, n_j;
    logic [15:0]   r_len, n_len;
    logic [15:0]   r_crc, n_crc;
    logic [15:0]   r_crc_rx, n_crc_rx;
    logic [7:0]    r_cmd, n_cmd;
    logic [15:0]   r_temp, n_temp;
    logic [31:0]   r_cur, n_cur;
    logic [31:0]   r_rpm, n_rpm;
    logic [7:0]    r_fault, n_fault;
    logic          r_acc, n_acc;
    logic          r_upd, n_upd;

    logic [AW-1:0] rd_idx;
    logic          rd_en;
    logic          go_back;
    logic [AW:0]   ds_w;
    logic [1:0]    tag_nlen;
    logic [15:0]   len_shift;
    logic [15:0]   off16;

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_end    = r_end;
        n_s      = r_s;
        n_ds     = r_ds;
        n_dl     = r_dl;
        n_off    = r_off;
        n_nlen   = r_nlen;
        n_j      = r_j;
        n_len    = r_len;
        n_crc    = r_crc;
        n_crc_rx = r_crc_rx;
        n_cmd    = r_cmd;
        n_temp   = r_temp;
        n_cur    = r_cur;
        n_rpm    = r_rpm;
        n_fault  = r_fault;
        n_acc    = r_acc;
        n_upd    = r_upd;
        rd_idx   = '0;
        rd_en    = 1'b0;
        go_back  = 1'b0;
        tag_nlen = 2'(i_rd_data - 8'd1);
        ds_w     = (AW+1)'(r_s) + (AW+1)'(tag_nlen) + (AW+1)'(1);
        len_shift = {r_len[7:0], i_rd_data};
        off16    = 16'(r_off);

        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_head = i_req.head;
                    n_end  = i_req.end_idx;
                    n_acc  = 1'b0;
                    n_upd  = 1'b0;
                    // a frame needs start, length, two crc bytes and the end byte
                    if (i_req.is_end && i_req.end_idx >= AW'(4)) begin
                        rd_en   = 1'b1;
                        rd_idx  = i_req.end_idx - AW'(2);
                        n_state = S_CRCH;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CRCH: begin
                n_crc_rx[15:8] = i_rd_data;
                rd_en   = 1'b1;
                rd_idx  = r_end - AW'(1);
                n_state = S_CRCL;
            end
            S_CRCL: begin
                n_crc_rx[7:0] = i_rd_data;
                // nearer starts cannot fit the length and crc bytes
                n_s     = r_end - AW'(4);
                rd_en   = 1'b1;
                rd_idx  = r_end - AW'(4);
                n_state = S_TAG;
            end
            S_TAG: begin
                if (i_rd_data >= START_MIN && i_rd_data <= START_MAX &&
                    ds_w + (AW+1)'(2) <= (AW+1)'(r_end)) begin
                    n_nlen  = tag_nlen;
                    n_ds    = ds_w[AW-1:0];
                    n_dl    = r_end - AW'(2) - ds_w[AW-1:0];
                    n_len   = '0;
                    n_j     = 2'd1;
                    rd_en   = 1'b1;
                    rd_idx  = r_s + AW'(1);
                    n_state = S_LEN;
                end else begin
                    go_back = 1'b1;
                end
            end
            S_LEN: begin
                n_len = len_shift;
                if (r_j == r_nlen) begin
                    if (len_shift == 16'(r_dl)) begin
                        n_crc = '0;
                        n_off = '0;
                        if (r_dl == '0) begin
                            n_state = S_CHK;
                        end else begin
                            rd_en   = 1'b1;
                            rd_idx  = r_ds;
                            n_state = S_CRC;
                        end
                    end else begin
                        go_back = 1'b1;
                    end
                end else begin
                    rd_en  = 1'b1;
                    rd_idx = r_s + AW'(1) + AW'(r_j);
                    n_j    = r_j + 2'd1;
                end
            end
            S_CRC: begin
                n_crc = crc_byte(r_crc, i_rd_data);
                // pick telemetry bytes off the walk, committed only on accept
                if (off16 == 16'd0) begin
                    n_cmd = i_rd_data;
                end
                if (off16 == OFF_TEMP || off16 == OFF_TEMP + 16'd1) begin
                    n_temp = {r_temp[7:0], i_rd_data};
                end
                if (off16 >= OFF_CURRENT && off16 <= OFF_CURRENT + 16'd3) begin
                    n_cur = {r_cur[23:0], i_rd_data};
                end
                if (off16 >= OFF_RPM && off16 <= OFF_RPM + 16'd3) begin
                    n_rpm = {r_rpm[23:0], i_rd_data};
                end
                if (off16 == OFF_FAULT) begin
                    n_fault = i_rd_data;
                end
                if ((AW+1)'(r_off) + (AW+1)'(1) == (AW+1)'(r_dl)) begin
                    n_state = S_CHK;
                end else begin
                    rd_en   = 1'b1;
                    rd_idx  = r_ds + r_off + AW'(1);
                    n_off   = r_off + AW'(1);
                end
            end
            S_CHK: begin
                if (r_crc == r_crc_rx) begin
                    n_acc   = 1'b1;
                    n_upd   = (16'(r_dl) >= MIN_VALUES_LEN) && (r_cmd == CMD_GET_VALUES);
                    n_state = S_DONE;
                end else begin
                    go_back = 1'b1;
                end
            end
            S_DONE: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (go_back) begin
            if (r_s == '0) begin
                n_state = S_DONE;
            end else begin
                n_s     = r_s - AW'(1);
                rd_en   = 1'b1;
                rd_idx  = r_s - AW'(1);
                n_state = S_TAG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= 1'b0;
            r_upd   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_upd   <= n_upd;
        end
        r_head   <= n_head;
        r_end    <= n_end;
        r_s      <= n_s;
        r_ds     <= n_ds;
        r_dl     <= n_dl;
        r_off    <= n_off;
        r_nlen   <= n_nlen;
        r_j      <= n_j;
        r_len    <= n_len;
        r_crc    <= n_crc;
        r_crc_rx <= n_crc_rx;
        r_cmd    <= n_cmd;
        r_temp   <= n_temp;
        r_cur    <= n_cur;
        r_rpm    <= n_rpm;
        r_fault  <= n_fault;
    end

    assign o_rd_en   = rd_en;
    assign o_rd_addr = buf_addr((r_state == S_IDLE) ? i_req.head : r_head, rd_idx);

    always_comb begin
        o_res             = '0;
        o_res.done        = (r_state == S_DONE);
        o_res.accepted    = r_acc;
        o_res.updated     = r_upd;
        o_res.start_idx   = r_s;
        o_res.payload_len = 10'(16'(r_dl));
        o_res.command     = (r_dl != '0) ? r_cmd : 8'h00;
        o_res.temperature = r_temp;
        o_res.current     = r_cur;
        o_res.rpm         = r_rpm;
        o_res.fault       = r_fault;
    end

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_state == S_IDLE)
        else $error("scan started while busy");

    a_accept_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_acc) |-> (AW+1)'(r_s) + (AW+1)'(4) <= (AW+1)'(r_end))
        else $error("accepted start leaves no room for length and crc");

    a_crc_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CRC |-> r_off < r_dl)
        else $error("crc walk past payload span");

    a_update_needs_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_upd) |-> (r_acc && 16'(r_dl) >= MIN_VALUES_LEN))
        else $error("telemetry update without a long accepted frame");

    a_done_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_ack) |=> r_state == S_DONE)
        else $error("result dropped before handoff");

endmodule

/* src/motor_link_packet_receiver_top.sv */
// channel  direction  handshake          payload
// rx byte  in         i_valid / o_ready  i_rx_byte
// result   out        o_valid / i_ready  o_frame_* , o_values_updated, telemetry
//
// a byte other than the end byte goes straight to the done state, as does an end byte that cannot
// close a frame; an end byte reads its two crc bytes, then searches backward index by index for a
// start byte; for each start byte that fits the span it reads the length bytes, and when that length
// matches the span it walks the payload through the crc and then compares (one buffer read a cycle)
// synchronous active-low reset empties the buffer and clears telemetry; no clearing pass
// a finished result waits in the output register; the next byte is taken meanwhile and
// its own result then waits until the output register is free

module motor_link_packet_receiver_top import mlpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_frame_accepted,
    output logic [7:0]  o_frame_command,
    output logic [9:0]  o_frame_payload_length,
    output logic        o_values_updated,
    output logic signed [31:0] o_motor_rpm,
    output logic signed [31:0] o_motor_current,
    output logic [7:0]  o_fault_code,
    output logic [15:0] o_fet_temperature
);

    logic [AW-1:0] r_head;
    logic [FW-1:0] r_fill;
    logic          r_busy;
    logic          r_out_valid;
    logic [31:0]   r_rpm;
    logic [31:0]   r_cur;
    logic [7:0]    r_fault;
    logic [15:0]   r_temp;

    logic          r_o_acc;
    logic [7:0]    r_o_cmd;
    logic [9:0]    r_o_len;
    logic          r_o_upd;
    logic [31:0]   r_o_rpm;
    logic [31:0]   r_o_cur;
    logic [7:0]    r_o_fault;
    logic [15:0]   r_o_temp;

    logic          in_acc;
    logic          full;
    logic [AW-1:0] wr_head;
    logic [AW-1:0] wr_idx;
    logic          ack;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    t_scan_req     req;
    t_scan_res     res;

    assign o_ready = !r_busy;
    assign in_acc  = i_valid && !r_busy;

    // full buffer: drop the oldest byte by moving the head
    assign full    = (r_fill >= FW'(BUF_BYTES));
    assign wr_head = !full ? r_head :
                     (r_head == AW'(BUF_BYTES - 1)) ? '0 : r_head + AW'(1);
    assign wr_idx  = full ? AW'(BUF_BYTES - 1) : r_fill[AW-1:0];

    assign ack = res.done && r_busy && (!r_out_valid || i_ready);

    always_comb begin
        req         = '0;
        req.start   = in_acc;
        req.is_end  = (i_rx_byte == END_BYTE);
        req.end_idx = wr_idx;
        req.head    = wr_head;
    end

    mlpr_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (buf_addr(wr_head, wr_idx)),
        .i_wdata (i_rx_byte),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    mlpr_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .i_ack     (ack),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_fill      <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_rpm       <= '0;
            r_cur       <= '0;
            r_fault     <= '0;
            r_temp      <= '0;
        end else begin
            if (in_acc) begin
                r_head <= wr_head;
                r_fill <= FW'(wr_idx) + FW'(1);
                r_busy <= 1'b1;
            end
            if (ack) begin
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
                if (res.accepted) begin
                    r_fill <= FW'(res.start_idx);
                end
                if (res.updated) begin
                    r_rpm   <= res.rpm;
                    r_cur   <= res.current;
                    r_fault <= res.fault;
                    r_temp  <= res.temperature;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ack) begin
            r_o_acc   <= res.accepted;
            r_o_cmd   <= res.accepted ? res.command : 8'h00;
            r_o_len   <= res.accepted ? res.payload_len : 10'd0;
            r_o_upd   <= res.updated;
            r_o_rpm   <= res.updated ? res.rpm : r_rpm;
            r_o_cur   <= res.updated ? res.current : r_cur;
            r_o_fault <= res.updated ? res.fault : r_fault;
            r_o_temp  <= res.updated ? res.temperature : r_temp;
        end
    end

    assign o_valid                = r_out_valid;
    assign o_frame_accepted       = r_o_acc;
    assign o_frame_command        = r_o_cmd;
    assign o_frame_payload_length = r_o_len;
    assign o_values_updated       = r_o_upd;
    assign o_motor_rpm            = r_o_rpm;
    assign o_motor_current        = r_o_cur;
    assign o_fault_code           = r_o_fault;
    assign o_fet_temperature      = r_o_temp;

endmodule

/* tb/motor_link_frame_checker.sv */
`timescale 1ns / 1ps

package link_crc_pkg;

    // crc16 xmodem, one data bit at a time, msb first
    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ data[i];
            c  = {c[14:0], 1'b0} ^ (fb ? mlpr_pkg::CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

endpackage

module motor_link_frame_checker import mlpr_pkg::*; import link_crc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_frame_accepted,
    input  logic [7:0]  i_frame_command,
    input  logic [9:0]  i_frame_payload_length,
    input  logic        i_values_updated,
    input  logic [31:0] i_motor_rpm,
    input  logic [31:0] i_motor_current,
    input  logic [7:0]  i_fault_code,
    input  logic [15:0] i_fet_temperature,
    output int          o_mismatch_count,
    output int          o_reports_pending
);

    typedef struct packed {
        logic        accepted;
        logic [7:0]  command;
        logic [9:0]  payload_len;
        logic        updated;
        logic [31:0] rpm;
        logic [31:0] current;
        logic [7:0]  fault;
        logic [15:0] temperature;
    } t_frame_report;

    logic [7:0]    rx_mem [BUF_BYTES];
    int            fill_level;
    logic [31:0]   rpm_q;
    logic [31:0]   current_q;
    logic [7:0]    fault_q;
    logic [15:0]   temp_q;
    t_frame_report pending_frame_reports[$];
    int            mismatches = 0;

    function automatic t_frame_report decode_rx_byte(input logic [7:0] b);
        t_frame_report rep;
        int            end_i;
        int            nlen;
        int            ds;
        int            dl;
        int            len_v;
        int            at;
        logic [15:0]   crc_calc;
        logic [15:0]   crc_seen;
        rep = '0;
        // full buffer drops the oldest byte
        if (fill_level >= BUF_BYTES) begin
            for (int i = 0; i < BUF_BYTES - 1; i++) begin
                rx_mem[i] = rx_mem[i + 1];
            end
            fill_level = BUF_BYTES - 1;
        end
        rx_mem[fill_level] = b;
        fill_level++;
        if (b == END_BYTE) begin
            end_i = fill_level - 1;
            // nearest start byte first, down to index 0
            for (int s = end_i; s >= 0; s--) begin
                if (rx_mem[s] < START_MIN || rx_mem[s] > START_MAX) continue;
                nlen = int'(rx_mem[s]) - 1;
                ds   = s + 1 + nlen;
                if (ds + 2 > end_i) continue;
                dl    = end_i - 2 - ds;
                len_v = 0;
                for (int j = 1; j <= nlen; j++) begin
                    len_v = (len_v << 8) | int'(rx_mem[s + j]);
                end
                if ((len_v & 'hFFFF) != dl) continue;
                crc_calc = '0;
                for (int j = 0; j < dl; j++) begin
                    crc_calc = crc16_next(crc_calc, rx_mem[ds + j]);
                end
                crc_seen = {rx_mem[end_i - 2], rx_mem[end_i - 1]};
                if (crc_calc != crc_seen) continue;
                rep.accepted    = 1'b1;
                rep.payload_len = 10'(dl);
                rep.command     = (dl > 0) ? rx_mem[ds] : 8'h00;
                if (dl >= MIN_VALUES_LEN && rep.command == CMD_GET_VALUES) begin
                    temp_q    = {rx_mem[ds + OFF_TEMP], rx_mem[ds + OFF_TEMP + 1]};
                    at        = ds + OFF_CURRENT;
                    current_q = {rx_mem[at], rx_mem[at + 1], rx_mem[at + 2], rx_mem[at + 3]};
                    at        = ds + OFF_RPM;
                    rpm_q     = {rx_mem[at], rx_mem[at + 1], rx_mem[at + 2], rx_mem[at + 3]};
                    fault_q   = rx_mem[ds + OFF_FAULT];
                    rep.updated = 1'b1;
                end
                fill_level = s;
                break;
            end
        end
        rep.rpm         = rpm_q;
        rep.current     = current_q;
        rep.fault       = fault_q;
        rep.temperature = temp_q;
        return rep;
    endfunction

    always @(posedge i_clk) begin
        t_frame_report got;
        t_frame_report want;
        if (!i_rst_n) begin
            fill_level = 0;
            rpm_q      = '0;
            current_q  = '0;
            fault_q    = '0;
            temp_q     = '0;
            pending_frame_reports.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = {i_frame_accepted, i_frame_command, i_frame_payload_length,
                       i_values_updated, i_motor_rpm, i_motor_current, i_fault_code,
                       i_fet_temperature};
                if (pending_frame_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result transaction with nothing expected", $time);
                    end
                end else begin
                    want = pending_frame_reports.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"%0t: exp acc=%0d cmd=%02h len=%0d upd=%0d",
                                      " rpm=%08h cur=%08h fault=%02h temp=%04h"},
                                     $time, want.accepted, want.command, want.payload_len,
                                     want.updated, want.rpm, want.current, want.fault,
                                     want.temperature);
                            $display({"%0t: got acc=%0d cmd=%02h len=%0d upd=%0d",
                                      " rpm=%08h cur=%08h fault=%02h temp=%04h"},
                                     $time, got.accepted, got.command, got.payload_len,
                                     got.updated, got.rpm, got.current, got.fault,
                                     got.temperature);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_frame_reports.push_back(decode_rx_byte(i_rx_byte));
            end
        end
        o_mismatch_count  <= mismatches;
        o_reports_pending <= pending_frame_reports.size();
    end

endmodule

/* tb/tb_motor_link_packet_receiver_top.sv */
`timescale 1ns / 1ps

module tb_motor_link_packet_receiver_top;
    import mlpr_pkg::*;
    import link_crc_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 1500;
    localparam int PHASE_BYTES  = 6;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_ready   = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic        o_frame_accepted;
    logic [7:0]  o_frame_command;
    logic [9:0]  o_frame_payload_length;
    logic        o_values_updated;
    logic signed [31:0] o_motor_rpm;
    logic signed [31:0] o_motor_current;
    logic [7:0]  o_fault_code;
    logic [15:0] o_fet_temperature;

    int          mismatch_count;
    int          reports_pending;
    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;
    int          bytes_sent         = 0;
    int          cycle_count        = 0;
    logic [7:0]  frame_bytes[$];

    motor_link_packet_receiver_top dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_ready                (o_ready),
        .i_rx_byte              (i_rx_byte),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_frame_accepted       (o_frame_accepted),
        .o_frame_command        (o_frame_command),
        .o_frame_payload_length (o_frame_payload_length),
        .o_values_updated       (o_values_updated),
        .o_motor_rpm            (o_motor_rpm),
        .o_motor_current        (o_motor_current),
        .o_fault_code           (o_fault_code),
        .o_fet_temperature      (o_fet_temperature)
    );

    motor_link_frame_checker u_frame_checker (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_valid),
        .i_in_ready             (o_ready),
        .i_rx_byte              (i_rx_byte),
        .i_out_valid            (o_valid),
        .i_out_ready            (i_ready),
        .i_frame_accepted       (o_frame_accepted),
        .i_frame_command        (o_frame_command),
        .i_frame_payload_length (o_frame_payload_length),
        .i_values_updated       (o_values_updated),
        .i_motor_rpm            (o_motor_rpm),
        .i_motor_current        (o_motor_current),
        .i_fault_code           (o_fault_code),
        .i_fet_temperature      (o_fet_temperature),
        .o_mismatch_count       (mismatch_count),
        .o_reports_pending      (reports_pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i]) begin
            send_byte(frame_bytes[i]);
        end
    endtask

    // start, 1..3 length bytes, payload led by the command, crc, end
    task automatic build_frame(input int plen, input logic [7:0] cmd, input int len_bytes,
                               input logic [7:0] len_top);
        logic [15:0] crc;
        logic [7:0]  data;
        frame_bytes.delete();
        frame_bytes.push_back(8'(START_MIN + len_bytes - 1));
        if (len_bytes == 3) begin
            frame_bytes.push_back(len_top);
        end
        if (len_bytes >= 2) begin
            frame_bytes.push_back(8'(plen >> 8));
        end
        frame_bytes.push_back(8'(plen));
        crc = '0;
        for (int i = 0; i < plen; i++) begin
            data = (i == 0) ? cmd : 8'($urandom);
            crc  = crc16_next(crc, data);
            frame_bytes.push_back(data);
        end
        frame_bytes.push_back(crc[15:8]);
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(END_BYTE);
    endtask

    // mostly good frames, some corrupted or cut short, some noise
    task automatic build_random_sequence();
        int         pick;
        int         plen;
        int         pos;
        logic [7:0] cmd;
        pick = $urandom_range(99);
        plen = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 12);
        cmd  = ($urandom_range(3) == 0) ? CMD_GET_VALUES : 8'($urandom);
        if (pick < 85) begin
            build_frame(plen, cmd, $urandom_range(1, 3),
                        ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom));
        end
        if (pick >= 70 && pick < 85) begin
            if ($urandom_range(2) == 0) begin
                void'(frame_bytes.pop_back());
            end else begin
                pos = $urandom_range(1, frame_bytes.size() - 2);
                frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
            end
        end else if (pick >= 85) begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty payload at index 0, lone end byte, wide length, short get-values
        build_frame(0, 8'h00, 1, 8'h00);
        send_frame();
        send_byte(END_BYTE);
        build_frame(1, 8'hFF, 3, 8'h01);
        send_frame();
        build_frame(2, CMD_GET_VALUES, 2, 8'h00);
        send_frame();

        for (int mode = 0; mode < 4; mode++) begin
            sender_idle_pct    = (mode == 1) ? 82 : (mode == 3) ? 23 : 0;
            receiver_stall_pct = (mode == 2) ? 82 : (mode == 3) ? 23 : 0;
            bytes_sent = 0;
            // long get-values frame refreshes the telemetry
            if (mode == 3) begin
                build_frame(60, CMD_GET_VALUES, 1, 8'h00);
                send_frame();
            end
            while (bytes_sent < PHASE_BYTES) begin
                build_random_sequence();
                send_frame();
            end
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (reports_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && reports_pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* motor_link_packet_receiver_top.f */
src/mlpr_pkg.sv
src/mlpr_ram.sv
src/mlpr_scan.sv
src/motor_link_packet_receiver_top.sv
tb/motor_link_frame_checker.sv
tb/tb_motor_link_packet_receiver_top.sv
